[rtl/rgru_pkg.sv]
package rgru_pkg;

    localparam int MAP_SIDE_DEF     = 1024;
    localparam int COUNTER_BITS_DEF = 16;
    localparam int WALK_MAX         = 2047;

    localparam logic REQ_BEAM = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BEAM_RD,
        ST_BEAM_WAIT,
        ST_BEAM_WR,
        ST_CELL_RD,
        ST_CELL_WAIT,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

[rtl/rgru_div.sv]
module rgru_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem  = w_trial - {1'b0, r_den};
                n_quot = {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_quot = {r_quot[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/reflection_grid_ray_update.sv]
// Reflection counting grid. Beam request: start cell to end cell walked along a Bresenham line,
// passes on every cell but the end cell, a hit on the end cell, counters saturating. Read
// request: counters of one cell and occupancy floor(100*hits/(hits+passes)), -1 if unseen.
// Both counters of a cell sit in one single-port memory word, so a beam reads, waits for
// and writes each cell walked in turn; a read's occupancy comes from a bit-serial divider.
// After reset a clearing pass zeroes every memory word with busy high. One result per
// request, shown for one cycle on o_done; the receiver cannot stall it, and busy stays low
// only after the result is delivered.
module reflection_grid_ray_update #(
    parameter int MAP_SIDE     = rgru_pkg::MAP_SIDE_DEF,
    parameter int COUNTER_BITS = rgru_pkg::COUNTER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [9:0]         i_start_x,
    input  logic [9:0]         i_start_y,
    input  logic signed [11:0] i_end_x,
    input  logic signed [11:0] i_end_y,
    output logic               o_done,
    output logic               o_beam_applied,
    output logic [10:0]        o_cells_walked,
    output logic [15:0]        o_hit_count,
    output logic [15:0]        o_pass_count,
    output logic signed [7:0]  o_occupancy
);

    localparam int CW     = COUNTER_BITS;
    localparam int AW     = $clog2(MAP_SIDE);
    localparam int IW     = 2 * AW;
    localparam int DEPTH  = 1 << IW;
    localparam int NUM_W  = CW + 7;
    localparam int DEN_W  = CW + 1;
    localparam logic [CW-1:0] CMAX = '1;
    localparam logic signed [13:0] SIDE14 = 14'(MAP_SIDE);

    rgru_pkg::t_state r_state, n_state;

    logic [2*CW-1:0] r_mem [DEPTH];
    logic [2*CW-1:0] r_rdata;
    logic [IW:0]     r_clr, n_clr;

    logic signed [13:0] r_x, n_x, r_y, n_y, r_x1, r_y1, r_dx, r_dy, r_err, n_err;
    logic signed [13:0] n_dx, n_dy;
    logic               r_sx, r_sy;
    logic [10:0]        r_walk, n_walk;
    logic               r_req, r_applied, n_applied;
    logic               r_valid, n_valid;
    logic [CW-1:0]      r_hit, n_hit, r_pass, n_pass;
    logic               r_done, n_done;
    logic [7:0]         r_occ, n_occ;

    logic            mem_we;
    logic [IW-1:0]   mem_addr;
    logic [2*CW-1:0] mem_wdata;
    logic            div_start, div_done;
    logic [NUM_W-1:0] div_quot;
    logic            accept;
    logic            w_last;
    logic signed [14:0] w_e2;
    logic signed [13:0] sx14, sy14, ex14, ey14;
    logic [CW-1:0]   w_h, w_p;
    logic            w_start_in, w_end_in;

    assign accept = start && !busy;
    assign busy   = (r_state != rgru_pkg::ST_IDLE);
    assign sx14   = {4'b0, i_start_x};
    assign sy14   = {4'b0, i_start_y};
    assign ex14   = 14'(i_end_x);
    assign ey14   = 14'(i_end_y);
    assign w_start_in = (sx14 < SIDE14) && (sy14 < SIDE14);
    assign w_end_in   = (ex14 >= 0) && (ey14 >= 0) && (ex14 < SIDE14) && (ey14 < SIDE14);
    assign w_last = (r_x == r_x1) && (r_y == r_y1);
    assign w_e2   = {r_err, 1'b0};
    assign w_h    = r_rdata[2*CW-1:CW];
    assign w_p    = r_rdata[CW-1:0];

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_x       = r_x;
        n_y       = r_y;
        n_err     = r_err;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_walk    = r_walk;
        n_applied = r_applied;
        n_valid   = r_valid;
        n_hit     = r_hit;
        n_pass    = r_pass;
        n_occ     = r_occ;
        n_done    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = {r_y[AW-1:0], r_x[AW-1:0]};
        mem_wdata = r_rdata;
        div_start = 1'b0;
        case (r_state)
            rgru_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr[IW-1:0];
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr[IW-1:0] == '1) begin
                    n_state = rgru_pkg::ST_IDLE;
                end
            end
            rgru_pkg::ST_IDLE: begin
                if (accept) begin
                    n_x       = sx14;
                    n_y       = sy14;
                    n_walk    = '0;
                    n_applied = 1'b0;
                    n_hit     = '0;
                    n_pass    = '0;
                    n_occ     = 8'hFF;
                    n_valid   = w_start_in;
                    n_dx      = (ex14 > sx14) ? ex14 - sx14 : sx14 - ex14;
                    n_dy      = (ey14 > sy14) ? sy14 - ey14 : ey14 - sy14;
                    n_err     = n_dx + n_dy;
                    if (i_req_type == rgru_pkg::REQ_READ) begin
                        n_state = w_start_in ? rgru_pkg::ST_CELL_RD : rgru_pkg::ST_DONE;
                    end else begin
                        n_occ = '0;
                        if (w_start_in && w_end_in) begin
                            n_applied = 1'b1;
                            n_state   = rgru_pkg::ST_BEAM_RD;
                        end else begin
                            n_state = rgru_pkg::ST_DONE;
                        end
                    end
                end
            end
            rgru_pkg::ST_BEAM_RD: begin
                n_state = rgru_pkg::ST_BEAM_WAIT;
            end
            rgru_pkg::ST_BEAM_WAIT: begin
                n_state = rgru_pkg::ST_BEAM_WR;
            end
            rgru_pkg::ST_BEAM_WR: begin
                mem_we = 1'b1;
                if (w_last) begin
                    mem_wdata = {(w_h == CMAX) ? CMAX : w_h + 1'b1, w_p};
                end else begin
                    mem_wdata = {w_h, (w_p == CMAX) ? CMAX : w_p + 1'b1};
                end
                if (r_walk != 11'(rgru_pkg::WALK_MAX)) begin
                    n_walk = r_walk + 1'b1;
                end
                if (w_last) begin
                    n_state = rgru_pkg::ST_DONE;
                end else begin
                    n_state = rgru_pkg::ST_BEAM_RD;
                    if (w_e2 >= 15'(r_dy)) begin
                        n_err = r_err + r_dy;
                        n_x   = r_sx ? r_x + 1'b1 : r_x - 1'b1;
                    end
                    if (w_e2 <= 15'(r_dx)) begin
                        n_err = n_err + r_dx;
                        n_y   = r_sy ? r_y + 1'b1 : r_y - 1'b1;
                    end
                end
            end
            rgru_pkg::ST_CELL_RD: begin
                n_state = rgru_pkg::ST_CELL_WAIT;
            end
            rgru_pkg::ST_CELL_WAIT: begin
                n_hit  = w_h;
                n_pass = w_p;
                if ((w_h == '0) && (w_p == '0)) begin
                    n_state = rgru_pkg::ST_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = rgru_pkg::ST_DIV;
                end
            end
            rgru_pkg::ST_DIV: begin
                if (div_done) begin
                    n_occ   = div_quot[7:0];
                    n_state = rgru_pkg::ST_DONE;
                end
            end
            rgru_pkg::ST_DONE: begin
                n_done  = 1'b1;
                n_state = rgru_pkg::ST_IDLE;
            end
            default: begin
                n_state = rgru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgru_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_x       <= n_x;
        r_y       <= n_y;
        r_err     <= n_err;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_walk    <= n_walk;
        r_applied <= n_applied;
        r_valid   <= n_valid;
        r_hit     <= n_hit;
        r_pass    <= n_pass;
        r_occ     <= n_occ;
        if (accept) begin
            r_x1  <= ex14;
            r_y1  <= ey14;
            r_sx  <= sx14 < ex14;
            r_sy  <= sy14 < ey14;
            r_req <= i_req_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    rgru_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (NUM_W'(w_h) * NUM_W'(100)),
        .i_den   (DEN_W'(w_h) + DEN_W'(w_p)),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_done         = r_done;
    assign o_beam_applied = r_applied;
    assign o_cells_walked = r_walk;
    assign o_hit_count    = 16'(r_hit);
    assign o_pass_count   = 16'(r_pass);
    assign o_occupancy    = r_occ;

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("busy after result");
    a_read_no_beam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_req == rgru_pkg::REQ_READ) |-> (!o_beam_applied && o_cells_walked == '0))
        else $error("beam fields on read");
    a_read_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_req == rgru_pkg::REQ_READ && !r_valid) |-> (o_occupancy == -8'sd1))
        else $error("read outside map not unknown");

endmodule
